// ===== rtl/core/f5t_pkg.sv =====
// Shared constants, codes and request type for the IPv4 five-tuple extractor.
package f5t_pkg;

	localparam int NUM_PORTS = 8;

	localparam int PORT_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int TIME_W  = 64;
	localparam int ADDR_W  = 32;
	localparam int L4_W    = 16;
	localparam int PROTO_W = 8;
	localparam int FLAG_W  = 6;
	localparam int LEN_W   = 16;
	localparam int OFF_W   = 7;
	localparam int CNT_W   = 8;
	localparam int HW_W    = 4;
	localparam int ETH_W   = 16;
	localparam int PKT_W   = 32;
	localparam int BCNT_W  = 48;
	localparam int ATTR_W  = 24;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 296;

	localparam logic [ETH_W-1:0]   ETH_IPV4  = 16'h0800;
	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'h06;
	localparam logic [PROTO_W-1:0] PROTO_UDP = 8'h11;
	localparam logic [FLAG_W-1:0]  FLAG_MASK = 6'h3f;

	// Frame byte offsets
	localparam logic [OFF_W-1:0] OFF_MAX   = 7'd127;
	localparam logic [OFF_W-1:0] OFF_ETH   = 7'd12;
	localparam logic [OFF_W-1:0] OFF_IHL   = 7'd14;
	localparam logic [OFF_W-1:0] OFF_LEN   = 7'd16;
	localparam logic [OFF_W-1:0] OFF_PROTO = 7'd23;
	localparam logic [OFF_W-1:0] OFF_SRC   = 7'd26;
	localparam logic [OFF_W-1:0] OFF_DST   = 7'd30;
	localparam logic [OFF_W-1:0] L4_BASE   = 7'd14;
	localparam logic [OFF_W-1:0] OFF_FLAGS = 7'd13;

	localparam logic [CNT_W-1:0] MIN_FRAME    = 8'd34;
	localparam logic [CNT_W-1:0] UDP_L4_NEED  = 8'd4;
	localparam logic [CNT_W-1:0] TCP_L4_NEED  = 8'd14;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef enum logic {
		RES_RECORD = 1'b0,
		RES_REPORT = 1'b1
	} res_kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [L4_W-1:0]    sport;
		logic [L4_W-1:0]    dport;
		logic [PROTO_W-1:0] proto;
		logic [FLAG_W-1:0]  flags;
		logic [LEN_W-1:0]   len;
		logic [TIME_W-1:0]  ts;
		logic [PORT_W-1:0]  port;
	} req_t;

endpackage

// ===== rtl/core/f5t_parser.sv =====
// Front end: byte-serial header parser that classifies frames and issues requests.
module f5t_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  f5t_pkg::kind_t              in_kind,
	input  logic [f5t_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        in_last,
	input  logic [f5t_pkg::PORT_W-1:0]  in_port,
	input  logic [f5t_pkg::TIME_W-1:0]  in_time,
	input  logic                        q_full,
	output logic                        push,
	output f5t_pkg::req_t               push_req
);

	logic [f5t_pkg::OFF_W-1:0]   off_q;
	logic [f5t_pkg::ETH_W-1:0]   eth_q,   eth_n;
	logic [f5t_pkg::PROTO_W-1:0] proto_q, proto_n;
	logic [f5t_pkg::HW_W-1:0]    hw_q,    hw_n;
	logic [f5t_pkg::ADDR_W-1:0]  src_q,   src_n;
	logic [f5t_pkg::ADDR_W-1:0]  dst_q,   dst_n;
	logic [f5t_pkg::LEN_W-1:0]   len_q,   len_n;
	logic [f5t_pkg::L4_W-1:0]    sport_q, sport_n;
	logic [f5t_pkg::L4_W-1:0]    dport_q, dport_n;
	logic [f5t_pkg::FLAG_W-1:0]  flags_q, flags_n;
	logic [f5t_pkg::TIME_W-1:0]  time_q,  time_n;
	logic [f5t_pkg::PORT_W-1:0]  port_q,  port_n;

	logic [f5t_pkg::OFF_W-1:0]   l4;
	logic [f5t_pkg::CNT_W-1:0]   count;
	logic [f5t_pkg::CNT_W-1:0]   need;
	logic                        accept;
	logic                        frame_byte;
	logic                        is_tcp;
	logic                        ok;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign frame_byte = accept && (in_kind == f5t_pkg::KIND_FRAME);

	// Next header state, with the current byte folded in
	always_comb begin
		eth_n   = eth_q;
		proto_n = proto_q;
		hw_n    = hw_q;
		src_n   = src_q;
		dst_n   = dst_q;
		len_n   = len_q;
		sport_n = sport_q;
		dport_n = dport_q;
		flags_n = flags_q;
		time_n  = time_q;
		port_n  = port_q;

		if (off_q == '0) begin
			time_n = in_time;
			port_n = in_port;
		end
		if (off_q == f5t_pkg::OFF_ETH)         eth_n[15:8] = in_byte;
		if (off_q == f5t_pkg::OFF_ETH + 7'd1)  eth_n[7:0]  = in_byte;
		if (off_q == f5t_pkg::OFF_IHL)         hw_n        = in_byte[3:0];
		if (off_q == f5t_pkg::OFF_LEN)         len_n[15:8] = in_byte;
		if (off_q == f5t_pkg::OFF_LEN + 7'd1)  len_n[7:0]  = in_byte;
		if (off_q == f5t_pkg::OFF_PROTO)       proto_n     = in_byte;
		if (off_q == f5t_pkg::OFF_SRC)         src_n[31:24] = in_byte;
		if (off_q == f5t_pkg::OFF_SRC + 7'd1)  src_n[23:16] = in_byte;
		if (off_q == f5t_pkg::OFF_SRC + 7'd2)  src_n[15:8]  = in_byte;
		if (off_q == f5t_pkg::OFF_SRC + 7'd3)  src_n[7:0]   = in_byte;
		if (off_q == f5t_pkg::OFF_DST)         dst_n[31:24] = in_byte;
		if (off_q == f5t_pkg::OFF_DST + 7'd1)  dst_n[23:16] = in_byte;
		if (off_q == f5t_pkg::OFF_DST + 7'd2)  dst_n[15:8]  = in_byte;
		if (off_q == f5t_pkg::OFF_DST + 7'd3)  dst_n[7:0]   = in_byte;

		// L4 start follows the IHL, which may arrive on this very byte
		l4 = f5t_pkg::L4_BASE + {1'b0, hw_n, 2'b00};
		if (off_q == l4)         sport_n[15:8] = in_byte;
		if (off_q == l4 + 7'd1)  sport_n[7:0]  = in_byte;
		if (off_q == l4 + 7'd2)  dport_n[15:8] = in_byte;
		if (off_q == l4 + 7'd3)  dport_n[7:0]  = in_byte;
		if (off_q == l4 + f5t_pkg::OFF_FLAGS)
			flags_n = in_byte[f5t_pkg::FLAG_W-1:0] & f5t_pkg::FLAG_MASK;

		is_tcp = (proto_n == f5t_pkg::PROTO_TCP);
		count  = {1'b0, off_q} + 8'd1;
		need   = {1'b0, l4} + (is_tcp ? f5t_pkg::TCP_L4_NEED : f5t_pkg::UDP_L4_NEED);
		if (need < f5t_pkg::MIN_FRAME)
			need = f5t_pkg::MIN_FRAME;
		ok = (eth_n == f5t_pkg::ETH_IPV4)
			&& (is_tcp || proto_n == f5t_pkg::PROTO_UDP)
			&& (count >= need);
	end

	assign push = accept && ((in_kind == f5t_pkg::KIND_READ) || (in_last && ok));

	always_comb begin
		push_req.kind  = in_kind;
		push_req.src   = src_n;
		push_req.dst   = dst_n;
		push_req.sport = sport_n;
		push_req.dport = dport_n;
		push_req.proto = proto_n;
		push_req.flags = is_tcp ? flags_n : '0;
		push_req.len   = len_n;
		push_req.ts    = time_n;
		push_req.port  = (in_kind == f5t_pkg::KIND_READ) ? in_port : port_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			eth_q   <= '0;
			proto_q <= '0;
			hw_q    <= '0;
		end else if (frame_byte) begin
			if (in_last)
				off_q <= '0;
			else if (off_q != f5t_pkg::OFF_MAX)
				off_q <= off_q + 7'd1;
			eth_q   <= eth_n;
			proto_q <= proto_n;
			hw_q    <= hw_n;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_byte) begin
			src_q   <= src_n;
			dst_q   <= dst_n;
			len_q   <= len_n;
			sport_q <= sport_n;
			dport_q <= dport_n;
			flags_q <= flags_n;
			time_q  <= time_n;
			port_q  <= port_n;
		end
	end

endmodule

// ===== rtl/core/f5t_queue.sv =====
// Short request queue between the parser and the counter back end.
module f5t_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  f5t_pkg::req_t push_req,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output f5t_pkg::req_t head
);

	f5t_pkg::req_t                mem_q [f5t_pkg::QUEUE_DEPTH];
	logic [f5t_pkg::QPTR_W-1:0]   wr_q;
	logic [f5t_pkg::QPTR_W-1:0]   rd_q;
	logic [f5t_pkg::QCNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == f5t_pkg::QCNT_W'(f5t_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_req;
	end

endmodule

// ===== rtl/core/f5t_counters.sv =====
// Back end: per-port saturating counters, read-and-clear, and the output register.
module f5t_counters (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  f5t_pkg::req_t                       head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [f5t_pkg::OUT_TDATA_W-1:0]     out_tdata,
	output f5t_pkg::res_kind_t                  out_tuser
);

	logic [f5t_pkg::PKT_W-1:0]  pkt_q  [f5t_pkg::NUM_PORTS];
	logic [f5t_pkg::BCNT_W-1:0] bcnt_q [f5t_pkg::NUM_PORTS];

	logic [f5t_pkg::PKT_W-1:0]  pkt_sel;
	logic [f5t_pkg::BCNT_W-1:0] bcnt_sel;
	logic                       in_range;
	logic [f5t_pkg::PKT_W-1:0]  pkt_sat;
	logic [f5t_pkg::BCNT_W:0]   bsum;
	logic [f5t_pkg::BCNT_W-1:0] bcnt_sat;
	logic [f5t_pkg::ATTR_W-1:0] attr;
	logic                       is_read;

	logic                              valid_q;
	logic [f5t_pkg::OUT_TDATA_W-1:0]   tdata_q;
	f5t_pkg::res_kind_t                tuser_q;

	assign is_read = (head.kind == f5t_pkg::KIND_READ);
	assign pop     = head_valid && (!valid_q || out_ready);

	always_comb begin
		pkt_sel  = '0;
		bcnt_sel = '0;
		in_range = 1'b0;
		for (int i = 0; i < f5t_pkg::NUM_PORTS; i++) begin
			if (int'(head.port) == i) begin
				pkt_sel  = pkt_q[i];
				bcnt_sel = bcnt_q[i];
				in_range = 1'b1;
			end
		end
		pkt_sat  = (pkt_sel == '1) ? pkt_sel : pkt_sel + 1'b1;
		bsum     = {1'b0, bcnt_sel} + {{(f5t_pkg::BCNT_W + 1 - f5t_pkg::LEN_W){1'b0}}, head.len};
		bcnt_sat = bsum[f5t_pkg::BCNT_W] ? '1 : bsum[f5t_pkg::BCNT_W-1:0];
		attr     = {head.proto, 2'b00, head.flags, 8'h00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < f5t_pkg::NUM_PORTS; i++) begin
				pkt_q[i]  <= '0;
				bcnt_q[i] <= '0;
			end
		end else if (pop && in_range) begin
			for (int i = 0; i < f5t_pkg::NUM_PORTS; i++) begin
				if (int'(head.port) == i) begin
					// Read clears; a record adds one packet and its IP length
					pkt_q[i]  <= is_read ? '0 : pkt_sat;
					bcnt_q[i] <= is_read ? '0 : bcnt_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (is_read) begin
				tuser_q <= f5t_pkg::RES_REPORT;
				tdata_q <= {5'b0, bcnt_sel, pkt_sel, head.port, 208'b0};
			end else begin
				tuser_q <= f5t_pkg::RES_RECORD;
				tdata_q <= {5'b0, {f5t_pkg::BCNT_W{1'b0}}, {f5t_pkg::PKT_W{1'b0}}, head.port,
					head.ts, head.len, attr, head.proto, head.dport, head.sport,
					head.dst, head.src};
			end
		end
	end

	assign out_valid = valid_q;
	assign out_tdata = tdata_q;
	assign out_tuser = tuser_q;

endmodule

// ===== rtl/core/ipv4_five_tuple_extractor.sv =====
// Top level of the IPv4 TCP/UDP five-tuple extractor with per-port counters.
// Frame bytes enter one per cycle with no gaps required: the parser takes a byte or a
// counter read request every cycle while its four-entry request queue has room. Each
// accepted frame that parses as IPv4 TCP or UDP and is long enough gives one metadata
// record after its last byte; a read request gives one counter report and clears that
// port's counters. The counter unit retires one queued request per cycle while its
// output register is empty or being taken, so results leave at up to one per cycle,
// registered first in the queue and then in the output register; input stalls only
// when output backpressure has filled the queue. No clearing pass follows reset.
module ipv4_five_tuple_extractor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// data_byte[7:0], port_index[10:8], arrival_time[74:11], zero[79:75]
	input  logic [f5t_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// kind
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// src_address[31:0], dst_address[63:32], src_l4_port[79:64], dst_l4_port[95:80],
	// protocol[103:96], attributes[127:104], ip_length[143:128],
	// frame_timestamp[207:144], frame_port[210:208], packet_total[242:211],
	// byte_total[290:243], zero[295:291]
	output logic [f5t_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// result_kind
	output logic                               m_axis_tuser
);

	logic               q_full;
	logic               push;
	f5t_pkg::req_t      push_req;
	logic               pop;
	logic               head_valid;
	f5t_pkg::req_t      head;
	f5t_pkg::kind_t     in_kind;
	f5t_pkg::res_kind_t out_kind;

	assign in_kind      = f5t_pkg::kind_t'(s_axis_tuser);
	assign m_axis_tuser = out_kind;

	f5t_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (in_kind),
		.in_byte  (s_axis_tdata[7:0]),
		.in_last  (s_axis_tlast),
		.in_port  (s_axis_tdata[10:8]),
		.in_time  (s_axis_tdata[74:11]),
		.q_full   (q_full),
		.push     (push),
		.push_req (push_req)
	);

	f5t_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	f5t_counters u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (out_kind)
	);

endmodule

// ===== rtl/core/f5t_checker.sv =====
// Port-level checker for the five-tuple extractor, bound to the top level.
module f5t_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [f5t_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                               m_axis_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed or dropped");

	// A report carries only port and counters
	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[207:0] == '0
			&& m_axis_tdata[295:291] == '0)
		else $error("counter report carries record fields");

	// A record is TCP or UDP with zero counters and matching attributes
	a_record_proto: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			(m_axis_tdata[103:96] == f5t_pkg::PROTO_TCP
				|| m_axis_tdata[103:96] == f5t_pkg::PROTO_UDP)
			&& m_axis_tdata[127:120] == m_axis_tdata[103:96]
			&& m_axis_tdata[111:104] == '0 && m_axis_tdata[119:118] == '0
			&& m_axis_tdata[295:211] == '0)
		else $error("malformed metadata record");

	// UDP records carry no flag bits
	a_udp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && m_axis_tdata[103:96] == f5t_pkg::PROTO_UDP
			|-> m_axis_tdata[119:112] == '0)
		else $error("UDP record with flag bits");

endmodule

bind ipv4_five_tuple_extractor f5t_checker u_f5t_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_ipv4_five_tuple_extractor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 five-tuple extractor and its per-port counters.
module tb_ipv4_five_tuple_extractor;

	typedef struct packed {
		f5t_pkg::res_kind_t          kind;
		logic [f5t_pkg::ADDR_W-1:0]  src;
		logic [f5t_pkg::ADDR_W-1:0]  dst;
		logic [f5t_pkg::L4_W-1:0]    sport;
		logic [f5t_pkg::L4_W-1:0]    dport;
		logic [f5t_pkg::PROTO_W-1:0] proto;
		logic [f5t_pkg::ATTR_W-1:0]  attr;
		logic [f5t_pkg::LEN_W-1:0]   len;
		logic [f5t_pkg::TIME_W-1:0]  ts;
		logic [f5t_pkg::PORT_W-1:0]  port;
		logic [f5t_pkg::PKT_W-1:0]   pkts;
		logic [f5t_pkg::BCNT_W-1:0]  octets;
	} flow_result_t;

	// Tracks parser and counter state, and the records and reports still owed by the block.
	class flow_scoreboard;
		flow_result_t                pending[$];
		int                          errors;
		int                          records_seen;
		int                          reports_seen;
		logic [f5t_pkg::OFF_W-1:0]   offset;
		logic [f5t_pkg::ETH_W-1:0]   ethertype;
		logic [f5t_pkg::PROTO_W-1:0] ip_proto;
		logic [f5t_pkg::HW_W-1:0]    ihl;
		logic [f5t_pkg::ADDR_W-1:0]  src_addr;
		logic [f5t_pkg::ADDR_W-1:0]  dst_addr;
		logic [f5t_pkg::LEN_W-1:0]   total_len;
		logic [f5t_pkg::L4_W-1:0]    src_l4;
		logic [f5t_pkg::L4_W-1:0]    dst_l4;
		logic [f5t_pkg::FLAG_W-1:0]  tcp_flags;
		logic [f5t_pkg::TIME_W-1:0]  first_time;
		logic [f5t_pkg::PORT_W-1:0]  first_port;
		logic [f5t_pkg::PKT_W-1:0]   pkt_count[f5t_pkg::NUM_PORTS];
		logic [f5t_pkg::BCNT_W-1:0]  byte_count[f5t_pkg::NUM_PORTS];

		function new();
			errors = 0;
			records_seen = 0;
			reports_seen = 0;
			offset = '0;
			ethertype = '0;
			ip_proto = '0;
			ihl = '0;
			src_addr = '0;
			dst_addr = '0;
			total_len = '0;
			src_l4 = '0;
			dst_l4 = '0;
			tcp_flags = '0;
			first_time = '0;
			first_port = '0;
			for (int i = 0; i < f5t_pkg::NUM_PORTS; i++) begin
				pkt_count[i] = '0;
				byte_count[i] = '0;
			end
		endfunction

		function void note_request(f5t_pkg::kind_t k, logic [f5t_pkg::BYTE_W-1:0] b,
				logic fend, logic [f5t_pkg::PORT_W-1:0] p, logic [f5t_pkg::TIME_W-1:0] t);
			flow_result_t              r;
			int                        off;
			int                        l4;
			int                        need;
			bit                        tcp;
			logic [f5t_pkg::BCNT_W:0]  byte_sum;
			r = '0;
			if (k == f5t_pkg::KIND_READ) begin
				r.kind = f5t_pkg::RES_REPORT;
				r.port = p;
				if (p < f5t_pkg::NUM_PORTS) begin
					r.pkts = pkt_count[p];
					r.octets = byte_count[p];
					pkt_count[p] = '0;
					byte_count[p] = '0;
				end
				pending.push_back(r);
				return;
			end
			off = offset;
			if (off == 0) begin
				first_time = t;
				first_port = p;
			end
			if (off == f5t_pkg::OFF_ETH) ethertype[15:8] = b;
			if (off == f5t_pkg::OFF_ETH + 1) ethertype[7:0] = b;
			if (off == f5t_pkg::OFF_IHL) ihl = b[3:0];
			if (off == f5t_pkg::OFF_LEN) total_len[15:8] = b;
			if (off == f5t_pkg::OFF_LEN + 1) total_len[7:0] = b;
			if (off == f5t_pkg::OFF_PROTO) ip_proto = b;
			if (off >= f5t_pkg::OFF_SRC && off < f5t_pkg::OFF_SRC + 4)
				src_addr[8 * (f5t_pkg::OFF_SRC + 3 - off) +: 8] = b;
			if (off >= f5t_pkg::OFF_DST && off < f5t_pkg::OFF_DST + 4)
				dst_addr[8 * (f5t_pkg::OFF_DST + 3 - off) +: 8] = b;
			// IHL taken at byte 14 already moves the L4 window for this same byte
			l4 = f5t_pkg::L4_BASE + 4 * ihl;
			if (off == l4) src_l4[15:8] = b;
			if (off == l4 + 1) src_l4[7:0] = b;
			if (off == l4 + 2) dst_l4[15:8] = b;
			if (off == l4 + 3) dst_l4[7:0] = b;
			if (off == l4 + f5t_pkg::OFF_FLAGS)
				tcp_flags = b[f5t_pkg::FLAG_W-1:0] & f5t_pkg::FLAG_MASK;
			if (!fend) begin
				if (offset < f5t_pkg::OFF_MAX) offset = offset + 1'b1;
				return;
			end
			offset = '0;
			tcp = (ip_proto == f5t_pkg::PROTO_TCP);
			need = tcp ? l4 + f5t_pkg::TCP_L4_NEED : l4 + f5t_pkg::UDP_L4_NEED;
			if (need < f5t_pkg::MIN_FRAME) need = f5t_pkg::MIN_FRAME;
			if (ethertype != f5t_pkg::ETH_IPV4 || !(tcp || ip_proto == f5t_pkg::PROTO_UDP)
					|| off + 1 < need)
				return;
			r.kind = f5t_pkg::RES_RECORD;
			r.src = src_addr;
			r.dst = dst_addr;
			r.sport = src_l4;
			r.dport = dst_l4;
			r.proto = ip_proto;
			r.attr = {ip_proto, tcp ? {2'b00, tcp_flags} : 8'h00, 8'h00};
			r.len = total_len;
			r.ts = first_time;
			r.port = first_port;
			if (first_port < f5t_pkg::NUM_PORTS) begin
				if (pkt_count[first_port] != '1) pkt_count[first_port] = pkt_count[first_port] + 1;
				byte_sum = {1'b0, byte_count[first_port]} + total_len;
				byte_count[first_port] = byte_sum[f5t_pkg::BCNT_W] ? '1
					: byte_sum[f5t_pkg::BCNT_W-1:0];
			end
			pending.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task check_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want) report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
		endtask

		task check_result(logic [f5t_pkg::OUT_TDATA_W-1:0] d, logic u);
			flow_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result with none outstanding, kind %0d", u));
				return;
			end
			want = pending.pop_front();
			if (want.kind == f5t_pkg::RES_REPORT) reports_seen++;
			else records_seen++;
			check_field("result_kind", u, want.kind);
			check_field("src_address", d[31:0], want.src);
			check_field("dst_address", d[63:32], want.dst);
			check_field("src_l4_port", d[79:64], want.sport);
			check_field("dst_l4_port", d[95:80], want.dport);
			check_field("protocol", d[103:96], want.proto);
			check_field("attributes", d[127:104], want.attr);
			check_field("ip_length", d[143:128], want.len);
			check_field("frame_timestamp", d[207:144], want.ts);
			check_field("frame_port", d[210:208], want.port);
			check_field("packet_total", d[242:211], want.pkts);
			check_field("byte_total", d[290:243], want.octets);
			check_field("pad", d[295:291], '0);
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [f5t_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            s_axis_tlast = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [f5t_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tuser;

	flow_scoreboard sb;
	logic [7:0]     frame_buf[$];
	int             tx_idle_pct = 0;
	int             rx_idle_pct = 0;
	int             read_pct = 0;
	int             items_sent = 0;
	int             reads_sent = 0;
	int             frames_sent = 0;

	ipv4_five_tuple_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	task automatic send_item(f5t_pkg::kind_t k, logic [7:0] b, logic fend, logic [2:0] p,
			logic [63:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tlast <= fend;
		s_axis_tdata <= {5'b0, t, p, b};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(k, b, fend, p, t);
		items_sent++;
		if (k == f5t_pkg::KIND_READ) reads_sent++;
	endtask

	// Hold the sender until every owed result is out, then let the pipeline settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic int frame_need(logic [7:0] proto, int ihl);
		int n;
		n = f5t_pkg::L4_BASE + 4 * ihl
			+ ((proto == f5t_pkg::PROTO_TCP) ? f5t_pkg::TCP_L4_NEED : f5t_pkg::UDP_L4_NEED);
		return (n < f5t_pkg::MIN_FRAME) ? f5t_pkg::MIN_FRAME : n;
	endfunction

	function automatic void build_frame(logic [15:0] eth, logic [7:0] proto, int ihl, int len,
			bit rand_fill, logic [7:0] fill);
		frame_buf.delete();
		for (int i = 0; i < len; i++) frame_buf.push_back(rand_fill ? 8'($urandom) : fill);
		if (len > 13) begin
			frame_buf[12] = eth[15:8];
			frame_buf[13] = eth[7:0];
		end
		if (len > 14) frame_buf[14] = {frame_buf[14][7:4], ihl[3:0]};
		if (len > 23) frame_buf[23] = proto;
	endfunction

	// Send frame_buf on one port; a read request can be slipped in ahead of byte read_at.
	task automatic send_frame(logic [2:0] p, logic [63:0] t, int read_at, logic [2:0] read_port);
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (i == read_at)
				send_item(f5t_pkg::KIND_READ, 8'($urandom), 1'($urandom), read_port,
					{$urandom, $urandom});
			else if ($urandom_range(99) < read_pct)
				send_item(f5t_pkg::KIND_READ, 8'($urandom), 1'($urandom), 3'($urandom),
					{$urandom, $urandom});
			send_item(f5t_pkg::KIND_FRAME, frame_buf[i], i == frame_buf.size() - 1, p, t);
		end
		frames_sent++;
	endtask

	task automatic random_frame();
		int          sel;
		int          ihl;
		int          len;
		logic [7:0]  proto;
		logic [15:0] eth;
		sel = $urandom_range(99);
		proto = $urandom_range(1) ? f5t_pkg::PROTO_TCP : f5t_pkg::PROTO_UDP;
		ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
		eth = f5t_pkg::ETH_IPV4;
		len = frame_need(proto, ihl) + $urandom_range(8);
		if (sel < 12) len = $urandom_range(frame_need(proto, ihl) - 1, 1);
		else if (sel < 17) len = $urandom_range(150, 120);
		else if (sel < 22) eth = 16'($urandom);
		else if (sel < 27) proto = 8'($urandom);
		build_frame(eth, proto, ihl, len, 1'b1, 8'h00);
		send_frame(3'($urandom), {$urandom, $urandom}, -1, 3'd0);
	endtask

	initial begin
		int base;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		send_item(f5t_pkg::KIND_READ, 8'h00, 1'b0, 3'd0, '0);
		send_item(f5t_pkg::KIND_READ, 8'hff, 1'b1, 3'd7, '1);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_UDP, 5, 1, 1'b1, 8'h00);
		send_frame(3'd2, 64'h1, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_UDP, 5,
			frame_need(f5t_pkg::PROTO_UDP, 5) - 1, 1'b1, 8'h00);
		send_frame(3'd3, {$urandom, $urandom}, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_UDP, 5,
			frame_need(f5t_pkg::PROTO_UDP, 5), 1'b0, 8'hff);
		send_frame(3'd7, '1, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_TCP, 5,
			frame_need(f5t_pkg::PROTO_TCP, 5), 1'b0, 8'h00);
		send_frame(3'd0, '0, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_TCP, 5,
			frame_need(f5t_pkg::PROTO_TCP, 5), 1'b1, 8'h00);
		frame_buf[47] = 8'hff;
		send_frame(3'd1, {$urandom, $urandom}, -1, 3'd0);
		// L4 header laid over the IP header
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_UDP, 0,
			frame_need(f5t_pkg::PROTO_UDP, 0), 1'b1, 8'h00);
		send_frame(3'd4, {$urandom, $urandom}, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_TCP, 2,
			frame_need(f5t_pkg::PROTO_TCP, 2), 1'b1, 8'h00);
		send_frame(3'd1, {$urandom, $urandom}, 20, 3'd1);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_TCP, 15,
			frame_need(f5t_pkg::PROTO_TCP, 15), 1'b1, 8'h00);
		send_frame(3'd5, {$urandom, $urandom}, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, f5t_pkg::PROTO_TCP, 5, 140, 1'b1, 8'h00);
		send_frame(3'd6, {$urandom, $urandom}, 60, 3'd6);
		build_frame(16'h86dd, f5t_pkg::PROTO_TCP, 5, 60, 1'b1, 8'h00);
		send_frame(3'd2, {$urandom, $urandom}, -1, 3'd0);
		build_frame(f5t_pkg::ETH_IPV4, 8'h01, 5, 60, 1'b1, 8'h00);
		send_frame(3'd2, {$urandom, $urandom}, -1, 3'd0);
		drain();
		for (int i = 0; i < f5t_pkg::NUM_PORTS; i++)
			send_item(f5t_pkg::KIND_READ, 8'h00, 1'b0, 3'(i), '0);
		drain();

		// random traffic in three pacing phases
		read_pct = 3;
		base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 65 : 0;
			rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 21 : 0;
			while (items_sent < base + 400 * (phase + 1)) random_frame();
			drain();
		end
		for (int i = 0; i < f5t_pkg::NUM_PORTS; i++)
			send_item(f5t_pkg::KIND_READ, 8'h00, 1'b0, 3'(i), '0);
		drain();
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
		$display("Sent %0d requests: %0d frames (short, long, non-IPv4, odd IHL) and %0d reads.",
			items_sent, frames_sent, reads_sent);
		$display("Checked %0d metadata records and %0d counter reports, %0d mismatches.",
			sb.records_seen, sb.reports_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", sb.pending.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/f5t_pkg.sv
rtl/core/f5t_parser.sv
rtl/core/f5t_queue.sv
rtl/core/f5t_counters.sv
rtl/core/ipv4_five_tuple_extractor.sv
rtl/core/f5t_checker.sv
verif/tb_ipv4_five_tuple_extractor.sv
